// ----- rtl/pci_pkg.sv -----
`timescale 1ns / 1ps
package pci_pkg;
    localparam int AREA_BITS_DEF = 24;
    localparam int W_BITS_DEF    = 32;
    localparam int COLOR_BITS    = 24;
    localparam int CH_BITS       = 8;
    localparam int NUM_CH        = 3;
    localparam int NUM_VTX       = 3;
    localparam logic [CH_BITS-1:0] CH_MAX = 8'hFF;
    // quotient bits: 8 result bits plus one overflow bit
    localparam int Q_BITS        = CH_BITS + 1;
    localparam int MUL_LAT       = 2;
    localparam int LANE_LAT      = 2 + Q_BITS;

    typedef logic [CH_BITS-1:0] chan_t;
endpackage

// ----- rtl/pci_if.sv -----
`timescale 1ns / 1ps
interface pci_frag_if;
    logic        valid;
    logic        ready;
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [23:0] color_c;
    logic [23:0] area_a;
    logic [23:0] area_b;
    logic [23:0] area_c;
    logic [31:0] depth_w_a;
    logic [31:0] depth_w_b;
    logic [31:0] depth_w_c;

    modport source (output valid, color_a, color_b, color_c, area_a, area_b, area_c,
                    depth_w_a, depth_w_b, depth_w_c, input ready);
    modport sink   (input valid, color_a, color_b, color_c, area_a, area_b, area_c,
                    depth_w_a, depth_w_b, depth_w_c, output ready);
endinterface

interface pci_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    logic        degenerate;

    modport source (output valid, pixel_color, degenerate, input ready);
    modport sink   (input valid, pixel_color, degenerate, output ready);
endinterface

// ----- rtl/pci_mul.sv -----
`timescale 1ns / 1ps
// pipelined multiplier, b split in halves: half products registered, then summed into a registered product
module pci_mul #(
    parameter int AW = 24,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AW+BL-1:0] lo_reg, lo_next;
    logic [AW+BH-1:0] hi_reg, hi_next;
    logic [PW-1:0]    p_reg, p_next;

    assign lo_next = (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
    assign hi_next = (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
    assign p_next  = PW'(lo_reg) + (PW'(hi_reg) << BL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;
endmodule

// ----- rtl/pci_lane.sv -----
`timescale 1ns / 1ps
// one color channel: weighted sum, then pipelined restoring divide
module pci_lane #(
    parameter int TW = 88
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [pci_pkg::NUM_VTX-1:0][TW-1:0]     term,
    input  logic [pci_pkg::NUM_VTX-1:0][7:0]        chan,
    input  logic [TW+1:0]                           den,
    output logic [7:0]                              q
);
    import pci_pkg::*;

    localparam int PRW = TW + CH_BITS;
    localparam int NW  = TW + CH_BITS + 2;
    localparam int DW  = TW + 2;

    logic [NUM_VTX-1:0][PRW-1:0] prod_reg;
    logic [NW-1:0]               num_reg;
    logic [DW-1:0]               dd_reg;
    logic [NW-1:0]               rem_reg [Q_BITS];
    logic [DW-1:0]               dq_reg  [Q_BITS];
    logic [Q_BITS-1:0]           q_reg   [Q_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_VTX; k++)
            begin
                prod_reg[k] <= PRW'(term[k]) * PRW'(chan[k]);
            end
            num_reg <= NW'(prod_reg[0]) + NW'(prod_reg[1]) + NW'(prod_reg[2]);
            dd_reg  <= den;
        end
    end

    for (genvar i = 0; i < Q_BITS; i++)
    begin : g_div
        localparam int B = Q_BITS - 1 - i;
        logic [NW-1:0]     rem_in;
        logic [DW-1:0]     d_in;
        logic [Q_BITS-1:0] q_in;
        logic [NW-1:0]     dsh;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign d_in   = dd_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign d_in   = dq_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign dsh = NW'(d_in) << B;
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? (rem_in - dsh) : rem_in;
                dq_reg[i]  <= d_in;
                q_reg[i]   <= {q_in[Q_BITS-2:0], ge};
            end
        end
    end

    assign q = q_reg[Q_BITS-1][Q_BITS-1] ? CH_MAX : q_reg[Q_BITS-1][CH_BITS-1:0];
endmodule

// ----- rtl/perspective_color_interpolator.sv -----
`timescale 1ns / 1ps
// Perspective-correct color interpolation, one fragment per clock.
// Pipeline from fragment transfer to pixel valid: two pipelined
// multipliers, product and sum stages, 9-stage divider per channel, output reg.
// Throughput: one fragment per cycle; the whole pipeline holds while the pixel stalls.
// Reset clears only the valid bits; data registers are not reset.
module perspective_color_interpolator #(
    parameter int AREA_BITS = pci_pkg::AREA_BITS_DEF,
    parameter int W_BITS    = pci_pkg::W_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pci_frag_if.sink  frag,
    pci_pix_if.source pix
);
    import pci_pkg::*;

    localparam int P1W = AREA_BITS + W_BITS;
    localparam int TW  = P1W + W_BITS;
    localparam int DW  = TW + 2;
    localparam int PIPE = 2 * MUL_LAT + LANE_LAT;
    localparam int CD  = 2 * MUL_LAT;

    logic en;
    logic out_v_reg;
    logic [COLOR_BITS-1:0] out_c_reg;
    logic out_d_reg;

    logic [NUM_VTX-1:0][AREA_BITS-1:0] area;
    logic [NUM_VTX-1:0][W_BITS-1:0]    wv;
    logic [NUM_VTX-1:0][COLOR_BITS-1:0] col;
    logic deg_in;

    logic [NUM_VTX-1:0][W_BITS-1:0] w_d_reg [MUL_LAT];
    logic [NUM_VTX-1:0][COLOR_BITS-1:0] col_reg [CD];
    logic [NUM_VTX-1:0][P1W-1:0] p1;
    logic [NUM_VTX-1:0][TW-1:0]  term;
    logic [DW-1:0] den_reg;
    logic [PIPE-1:0] vld_reg;
    logic [PIPE-1:0] deg_reg;
    chan_t [NUM_CH-1:0] q;

    assign en = !out_v_reg || pix.ready;
    assign frag.ready = en;

    assign area[0] = AREA_BITS'(frag.area_a);
    assign area[1] = AREA_BITS'(frag.area_b);
    assign area[2] = AREA_BITS'(frag.area_c);
    assign wv[0] = W_BITS'(frag.depth_w_a);
    assign wv[1] = W_BITS'(frag.depth_w_b);
    assign wv[2] = W_BITS'(frag.depth_w_c);
    assign col[0] = frag.color_a;
    assign col[1] = frag.color_b;
    assign col[2] = frag.color_c;

    // zero area sum means all areas zero
    assign deg_in = ((area[0] | area[1] | area[2]) == '0)
                 || (wv[0] == '0) || (wv[1] == '0) || (wv[2] == '0);

    for (genvar k = 0; k < NUM_VTX; k++)
    begin : g_term
        pci_mul #(.AW(AREA_BITS), .BW(W_BITS)) u_mul1 (
            .clk (clk),
            .en  (en),
            .a   (area[k]),
            .b   (wv[(k + 1) % NUM_VTX]),
            .p   (p1[k])
        );
        pci_mul #(.AW(P1W), .BW(W_BITS)) u_mul2 (
            .clk (clk),
            .en  (en),
            .a   (p1[k]),
            .b   (w_d_reg[MUL_LAT-1][(k + 2) % NUM_VTX]),
            .p   (term[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_d_reg[0] <= wv;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                w_d_reg[i] <= w_d_reg[i-1];
            end
            col_reg[0] <= col;
            for (int i = 1; i < CD; i++)
            begin
                col_reg[i] <= col_reg[i-1];
            end
            den_reg <= DW'(term[0]) + DW'(term[1]) + DW'(term[2]);
            deg_reg <= {deg_reg[PIPE-2:0], deg_in};
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        localparam int SH = CH_BITS * (NUM_CH - 1 - c);
        logic [NUM_VTX-1:0][CH_BITS-1:0] chan;
        for (genvar k = 0; k < NUM_VTX; k++)
        begin : g_ch
            assign chan[k] = col_reg[CD-1][k][SH +: CH_BITS];
        end
        pci_lane #(.TW(TW)) u_lane (
            .clk  (clk),
            .en   (en),
            .term (term),
            .chan (chan),
            .den  (den_reg),
            .q    (q[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[PIPE-2:0], frag.valid};
            out_v_reg <= vld_reg[PIPE-1];
        end
    end

    // merge lanes, or force the color to zero for a degenerate fragment
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= deg_reg[PIPE-1];
            out_c_reg <= deg_reg[PIPE-1] ? '0 : {q[0], q[1], q[2]};
        end
    end

    assign pix.valid       = out_v_reg;
    assign pix.pixel_color = out_c_reg;
    assign pix.degenerate  = out_d_reg;

    a_deg_black: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.degenerate) |-> (pix.pixel_color == '0))
        else $error("degenerate pixel with nonzero color");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && !pix.ready) |-> !frag.ready)
        else $error("fragment taken while pixel stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !frag.valid) |=> !vld_reg[0])
        else $error("pipeline valid without fragment transfer");
endmodule

// ----- tb/tb_perspective_color_interpolator.sv -----
`timescale 1ns / 1ps
module tb_perspective_color_interpolator;
    import pci_pkg::*;

    typedef struct packed {
        logic [23:0] color_a, color_b, color_c;
        logic [23:0] area_a, area_b, area_c;
        logic [31:0] w_a, w_b, w_c;
    } frag_t;

    typedef struct packed {
        logic [23:0] color;
        logic        degen;
    } pixel_t;

    logic clk;
    logic rst_n;

    pci_frag_if frag ();
    pci_pix_if  pix ();

    perspective_color_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frag  (frag.sink),
        .pix   (pix.source)
    );

    pixel_t expected_pixels[$];
    int     errors;
    int     pixels_seen;
    int     degen_seen;
    int     idle_cycles;
    bit     send_idle_en;
    bit     recv_idle_en;
    bit     recv_hold;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic pixel_t interpolate(frag_t f);
        logic [23:0]  col[3];
        logic [23:0]  ar[3];
        logic [31:0]  w[3];
        logic [127:0] term[3];
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] q;
        pixel_t       p;
        col = '{f.color_a, f.color_b, f.color_c};
        ar  = '{f.area_a, f.area_b, f.area_c};
        w   = '{f.w_a, f.w_b, f.w_c};
        p = '0;
        if ((ar[0] + ar[1] + ar[2]) == 0 || w[0] == 0 || w[1] == 0 || w[2] == 0)
        begin
            p.degen = 1'b1;
            return p;
        end
        for (int k = 0; k < 3; k++)
            term[k] = 128'(ar[k]) * 128'(w[(k + 1) % 3]) * 128'(w[(k + 2) % 3]);
        den = term[0] + term[1] + term[2];
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            num = 0;
            for (int k = 0; k < 3; k++)
                num += term[k] * 128'(col[k][16 - 8 * ch +: 8]);
            q = num / den;
            p.color[16 - 8 * ch +: 8] = (q > 255) ? CH_MAX : q[7:0];
        end
        return p;
    endfunction

    function automatic logic [31:0] rand_w();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 255);
            1: return 32'h0001_0000;
            2: return $urandom;
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(32'h0000_8000, 32'h0040_0000);
        endcase
    endfunction

    function automatic logic [23:0] rand_area();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'($urandom_range(0, 15));
            2: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_frag(frag_t f);
        while (send_idle_en && $urandom_range(0, 99) < 24)
        begin
            frag.valid <= 1'b0;
            @(posedge clk);
        end
        frag.valid     <= 1'b1;
        frag.color_a   <= f.color_a;
        frag.color_b   <= f.color_b;
        frag.color_c   <= f.color_c;
        frag.area_a    <= f.area_a;
        frag.area_b    <= f.area_b;
        frag.area_c    <= f.area_c;
        frag.depth_w_a <= f.w_a;
        frag.depth_w_b <= f.w_b;
        frag.depth_w_c <= f.w_c;
        // ready only changes at rising edges, so the value at the falling
        // edge is the one seen by the next rising edge
        @(negedge clk);
        while (!frag.ready)
            @(negedge clk);
        @(posedge clk);
        expected_pixels.push_back(interpolate(f));
    endtask

    function automatic frag_t rand_frag(bit degen_ok);
        frag_t f;
        f.color_a = 24'($urandom);
        f.color_b = 24'($urandom);
        f.color_c = 24'($urandom);
        f.area_a  = rand_area();
        f.area_b  = rand_area();
        f.area_c  = rand_area();
        f.w_a     = rand_w();
        f.w_b     = rand_w();
        f.w_c     = rand_w();
        if (degen_ok && $urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0: f.w_a = 0;
                1: f.w_b = 0;
                2: f.w_c = 0;
                default: {f.area_a, f.area_b, f.area_c} = '0;
            endcase
        end
        return f;
    endfunction

    task automatic test_directed();
        frag_t f;
        f = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        send_frag(f);
        f = '{24'h000000, 24'h000000, 24'h000000, 24'h000001, 24'h000001, 24'h000001,
              32'h1, 32'h1, 32'h1};
        send_frag(f);
        f = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'd1, 24'd1, 24'd1,
              32'h10000, 32'h10000, 32'h10000};
        send_frag(f);
        f = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'd0, 24'd0,
              32'h1, 32'hFFFFFFFF, 32'h10000};
        send_frag(f);
        f = '{24'h123456, 24'hABCDEF, 24'h55AA55, 24'd0, 24'hFFFFFF, 24'd0,
              32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF};
        send_frag(f);
        f = '{24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'd0, 24'd0, 24'd0,
              32'h10000, 32'h10000, 32'h10000};
        send_frag(f);
        f = '{24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'd5, 24'd6, 24'd7,
              32'h0, 32'h10000, 32'h10000};
        send_frag(f);
        f.w_a = 32'h10000;
        f.w_b = 32'h0;
        send_frag(f);
        f.w_b = 32'h10000;
        f.w_c = 32'h0;
        send_frag(f);
        f = '{24'hFFFFFF, 24'h000000, 24'h808080, 24'd1, 24'hFFFFFF, 24'd3,
              32'h1, 32'h8000_0000, 32'h0000_FFFF};
        send_frag(f);
        f = '{24'h0F0F0F, 24'hF0F0F0, 24'h00FF00, 24'd7, 24'd7, 24'd0,
              32'h5555_5555, 32'hAAAA_AAAA, 32'h1};
        send_frag(f);
    endtask

    task automatic test_random(int count, bit idles);
        send_idle_en = idles;
        recv_idle_en = idles;
        repeat (count)
            send_frag(rand_frag(1'b1));
    endtask

    task automatic test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (60)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (80)
                send_frag(rand_frag(1'b1));
        join
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pix.ready <= 1'b0;
        else
            pix.ready <= !recv_hold && !(recv_idle_en && $urandom_range(0, 99) < 24);
    end

    always @(posedge clk)
    begin
        pixel_t exp_p;
        if (rst_n && pix.valid && pix.ready)
        begin
            pixels_seen++;
            if (pix.degenerate)
                degen_seen++;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel with none expected: color %06h degenerate %0b",
                         $time, pix.pixel_color, pix.degenerate);
            end
            else
            begin
                exp_p = expected_pixels.pop_front();
                if (pix.pixel_color !== exp_p.color)
                begin
                    errors++;
                    $display("%0t: pixel_color expected %06h actual %06h",
                             $time, exp_p.color, pix.pixel_color);
                end
                if (pix.degenerate !== exp_p.degen)
                begin
                    errors++;
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, exp_p.degen, pix.degenerate);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frag.valid && frag.ready) || (pix.valid && pix.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        pixels_seen  = 0;
        degen_seen   = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        recv_hold    = 1'b0;
        rst_n        = 1'b0;
        frag.valid   = 1'b0;
        frag.color_a = '0;
        frag.color_b = '0;
        frag.color_c = '0;
        frag.area_a  = '0;
        frag.area_b  = '0;
        frag.area_c  = '0;
        frag.depth_w_a = '0;
        frag.depth_w_b = '0;
        frag.depth_w_c = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300, 1'b1);
        test_backpressure();
        test_random(200, 1'b0);
        test_random(170, 1'b1);
        frag.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LANE_LAT + 2 * MUL_LAT + 10)
            @(posedge clk);
        $display("Checked %0d pixels (%0d degenerate) across extremes, random fragments,",
                 pixels_seen, degen_seen);
        $display("random idling on both sides and a long output stall.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
